// ===== src/sorted_list_intersection_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list intersection core.
// Both macros sample on the rising edge of clock and are off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INTERSECTION_CORE_MACROS_SVH
`define SORTED_LIST_INTERSECTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SLIX_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SLIX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SLIX_ASSERT_IMPLIES(label, ante, cons, msg)
`define SLIX_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/slix_pkg.sv =====
// ----------------------------------------------------------------------------
// slix_pkg
// Shared types and constants of the sorted list intersection core.
// ----------------------------------------------------------------------------
package slix_pkg;

   localparam int ValueWidth = 32;
   localparam int ResultCountWidth = 6;
   // A run delivers at most this many transactions.
   localparam logic [ResultCountWidth-1:0] ResultLimit = 6'd32;

   typedef logic [1:0] action_type;
   localparam action_type ACT_LOAD_A = 2'd0;
   localparam action_type ACT_LOAD_B = 2'd1;
   localparam action_type ACT_RUN    = 2'd2;

   typedef struct packed {
      logic signed [ValueWidth-1:0] common_value;
      logic                         is_last;
      logic                         is_empty;
      logic                         overflow;
   } rsp_payload_type;

endpackage

// ===== src/slix_chan_if.sv =====
// ----------------------------------------------------------------------------
// slix channel interfaces
// Valid/ready channels for requests and results of the intersection core.
// ----------------------------------------------------------------------------
interface slix_req_if;
   logic                                   valid;
   logic                                   ready;
   slix_pkg::action_type                   action;
   logic signed [slix_pkg::ValueWidth-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

interface slix_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [slix_pkg::ValueWidth-1:0] common_value;
   logic                                   is_last;
   logic                                   is_empty;
   logic                                   overflow;

   modport source (output valid, output common_value, output is_last, output is_empty,
                   output overflow, input ready);
   modport sink (input valid, input common_value, input is_last, input is_empty,
                 input overflow, output ready);
endinterface

// ===== src/slix_ram.sv =====
// ----------------------------------------------------------------------------
// slix_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module slix_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/slix_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// slix_rsp_buf
// Output register of the result channel; decouples the merge from the sink.
// ----------------------------------------------------------------------------
module slix_rsp_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  slix_pkg::rsp_payload_type push_data,
   output logic                      can_push,
   slix_rsp_if.source                rsp_chan
);

   logic                      valid_ff;
   logic                      valid_in;
   slix_pkg::rsp_payload_type data_ff;
   slix_pkg::rsp_payload_type data_in;

   assign can_push = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = push || (valid_ff && !rsp_chan.ready);
      data_in  = push ? push_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.common_value = data_ff.common_value;
   assign rsp_chan.is_last      = data_ff.is_last;
   assign rsp_chan.is_empty     = data_ff.is_empty;
   assign rsp_chan.overflow     = data_ff.overflow;

endmodule

// ===== src/sorted_list_intersection_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_intersection_core: intersection of two loaded lists by sort and merge.
// Load: direct write into an empty list, overflow on a full one, else an insertion walk
// shifts larger elements up. Run: one compare unit merges, sink stalls can hold it.
// Synchronous reset clears counts, flags and the sequencer; list RAMs are not cleared.
// ----------------------------------------------------------------------------
`include "sorted_list_intersection_core_macros.svh"

module sorted_list_intersection_core #(
   parameter int MAX_ITEMS = 32
) (
   input logic         clock,
   input logic         reset,
   slix_req_if.sink    req_chan,
   slix_rsp_if.source  rsp_chan
);

   localparam int AddrWidth  = $clog2(MAX_ITEMS);
   localparam int CountWidth = $clog2(MAX_ITEMS + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(MAX_ITEMS);
   localparam logic [CountWidth-1:0] CountOne  = CountWidth'(1);
   localparam logic [CountWidth-1:0] CountTwo  = CountWidth'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_LAST,
      ST_MRG_CMP,
      ST_FLUSH
   } state_type;

   state_type                              state_ff, state_in;
   logic [CountWidth-1:0]                  cnt_a_ff, cnt_a_in;
   logic [CountWidth-1:0]                  cnt_b_ff, cnt_b_in;
   logic                                   ovf_ff, ovf_in;
   logic                                   sel_b_ff, sel_b_in;
   logic signed [slix_pkg::ValueWidth-1:0] ins_val_ff, ins_val_in;
   logic [CountWidth-1:0]                  pos_ff, pos_in;
   logic [CountWidth-1:0]                  ia_ff, ia_in;
   logic [CountWidth-1:0]                  ib_ff, ib_in;
   logic [slix_pkg::ResultCountWidth-1:0]  match_ff, match_in;
   logic                                   pend_v_ff, pend_v_in;
   logic signed [slix_pkg::ValueWidth-1:0] pend_val_ff, pend_val_in;

   logic                                   req_accept;
   logic [CountWidth-1:0]                  cnt_req;
   logic [CountWidth-1:0]                  cnt_m1;
   logic [CountWidth-1:0]                  pos_m2;
   logic [CountWidth-1:0]                  ia_nx;
   logic [CountWidth-1:0]                  ib_nx;
   logic [slix_pkg::ResultCountWidth-1:0]  match_nx;

   logic                                   lsel;
   logic                                   wr_en;
   logic [AddrWidth-1:0]                   wr_addr;
   logic [slix_pkg::ValueWidth-1:0]        wr_data;
   logic                                   ra_re, rb_re;
   logic [AddrWidth-1:0]                   ra_addr, rb_addr;
   logic [slix_pkg::ValueWidth-1:0]        ra_q, rb_q;
   logic signed [slix_pkg::ValueWidth-1:0] ins_q;

   logic                                   rsp_push;
   logic                                   rsp_can_push;
   slix_pkg::rsp_payload_type              rsp_data;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign cnt_req  = (req_chan.action == slix_pkg::ACT_LOAD_B) ? cnt_b_ff : cnt_a_ff;
   assign cnt_m1   = cnt_req - CountOne;
   assign pos_m2   = pos_ff - CountTwo;
   assign ia_nx    = ia_ff + CountOne;
   assign ib_nx    = ib_ff + CountOne;
   assign match_nx = match_ff + slix_pkg::ResultCountWidth'(1);
   assign ins_q    = $signed(sel_b_ff ? rb_q : ra_q);

   always_comb begin
      state_in    = state_ff;
      cnt_a_in    = cnt_a_ff;
      cnt_b_in    = cnt_b_ff;
      ovf_in      = ovf_ff;
      sel_b_in    = sel_b_ff;
      ins_val_in  = ins_val_ff;
      pos_in      = pos_ff;
      ia_in       = ia_ff;
      ib_in       = ib_ff;
      match_in    = match_ff;
      pend_v_in   = pend_v_ff;
      pend_val_in = pend_val_ff;
      lsel        = sel_b_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = ins_val_ff;
      ra_re       = 1'b0;
      rb_re       = 1'b0;
      ra_addr     = '0;
      rb_addr     = '0;
      rsp_push    = 1'b0;
      rsp_data.common_value = pend_val_ff;
      rsp_data.is_last      = 1'b0;
      rsp_data.is_empty     = 1'b0;
      rsp_data.overflow     = ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            lsel = (req_chan.action == slix_pkg::ACT_LOAD_B);
            if (req_accept) begin
               unique case (req_chan.action)
                  slix_pkg::ACT_LOAD_A, slix_pkg::ACT_LOAD_B: begin
                     if (cnt_req == CountFull) begin
                        ovf_in = 1'b1;
                     end else begin
                        sel_b_in   = lsel;
                        ins_val_in = req_chan.value;
                        pos_in     = cnt_req;
                        if (cnt_req == '0) begin
                           wr_en   = 1'b1;
                           wr_data = req_chan.value;
                           if (lsel) begin
                              cnt_b_in = cnt_b_ff + CountOne;
                           end else begin
                              cnt_a_in = cnt_a_ff + CountOne;
                           end
                        end else begin
                           // Start the insertion walk at the current tail.
                           ra_re    = !lsel;
                           rb_re    = lsel;
                           ra_addr  = cnt_m1[AddrWidth-1:0];
                           rb_addr  = cnt_m1[AddrWidth-1:0];
                           state_in = ST_INS_CMP;
                        end
                     end
                  end
                  slix_pkg::ACT_RUN: begin
                     ia_in     = '0;
                     ib_in     = '0;
                     match_in  = '0;
                     pend_v_in = 1'b0;
                     if (cnt_a_ff == '0 || cnt_b_ff == '0) begin
                        state_in = ST_FLUSH;
                     end else begin
                        ra_re    = 1'b1;
                        rb_re    = 1'b1;
                        state_in = ST_MRG_CMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INS_CMP: begin
            if (ins_q > ins_val_ff) begin
               // Shift the larger element up one place and keep walking down.
               wr_en   = 1'b1;
               wr_addr = pos_ff[AddrWidth-1:0];
               wr_data = ins_q;
               pos_in  = pos_ff - CountOne;
               if (pos_ff == CountOne) begin
                  state_in = ST_INS_LAST;
               end else begin
                  ra_re   = !sel_b_ff;
                  rb_re   = sel_b_ff;
                  ra_addr = pos_m2[AddrWidth-1:0];
                  rb_addr = pos_m2[AddrWidth-1:0];
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AddrWidth-1:0];
               state_in = ST_IDLE;
               if (sel_b_ff) begin
                  cnt_b_in = cnt_b_ff + CountOne;
               end else begin
                  cnt_a_in = cnt_a_ff + CountOne;
               end
            end
         end

         ST_INS_LAST: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
            if (sel_b_ff) begin
               cnt_b_in = cnt_b_ff + CountOne;
            end else begin
               cnt_a_in = cnt_a_ff + CountOne;
            end
         end

         ST_MRG_CMP: begin
            if ($signed(ra_q) == $signed(rb_q)) begin
               // A match waits in the pending register until we know whether it is last.
               if (!pend_v_ff || rsp_can_push) begin
                  rsp_push    = pend_v_ff;
                  pend_v_in   = 1'b1;
                  pend_val_in = $signed(ra_q);
                  match_in    = match_nx;
                  ia_in       = ia_nx;
                  ib_in       = ib_nx;
                  if (ia_nx == cnt_a_ff || ib_nx == cnt_b_ff ||
                      match_nx == slix_pkg::ResultLimit) begin
                     state_in = ST_FLUSH;
                  end else begin
                     ra_re   = 1'b1;
                     rb_re   = 1'b1;
                     ra_addr = ia_nx[AddrWidth-1:0];
                     rb_addr = ib_nx[AddrWidth-1:0];
                  end
               end
            end else if ($signed(ra_q) < $signed(rb_q)) begin
               ia_in = ia_nx;
               if (ia_nx == cnt_a_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  ra_re   = 1'b1;
                  ra_addr = ia_nx[AddrWidth-1:0];
               end
            end else begin
               ib_in = ib_nx;
               if (ib_nx == cnt_b_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  rb_re   = 1'b1;
                  rb_addr = ib_nx[AddrWidth-1:0];
               end
            end
         end

         ST_FLUSH: begin
            rsp_data.is_last  = 1'b1;
            rsp_data.is_empty = !pend_v_ff;
            if (!pend_v_ff) begin
               rsp_data.common_value = '0;
            end
            if (rsp_can_push) begin
               rsp_push  = 1'b1;
               cnt_a_in  = '0;
               cnt_b_in  = '0;
               ovf_in    = 1'b0;
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_a_ff  <= '0;
         cnt_b_ff  <= '0;
         ovf_ff    <= 1'b0;
         pend_v_ff <= 1'b0;
         match_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_a_ff  <= cnt_a_in;
         cnt_b_ff  <= cnt_b_in;
         ovf_ff    <= ovf_in;
         pend_v_ff <= pend_v_in;
         match_ff  <= match_in;
      end
      sel_b_ff    <= sel_b_in;
      ins_val_ff  <= ins_val_in;
      pos_ff      <= pos_in;
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      pend_val_ff <= pend_val_in;
   end

   slix_ram #(
      .Width (slix_pkg::ValueWidth),
      .Depth (MAX_ITEMS)
   ) u_list_a (
      .clock   (clock),
      .wr_en   (wr_en && !lsel),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ra_re),
      .rd_addr (ra_addr),
      .rd_data (ra_q)
   );

   slix_ram #(
      .Width (slix_pkg::ValueWidth),
      .Depth (MAX_ITEMS)
   ) u_list_b (
      .clock   (clock),
      .wr_en   (wr_en && lsel),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rb_re),
      .rd_addr (rb_addr),
      .rd_data (rb_q)
   );

   slix_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .can_push  (rsp_can_push),
      .rsp_chan  (rsp_chan)
   );

   `SLIX_ASSERT_IMPLIES(a_merge_in_range, state_ff == ST_MRG_CMP,
      (ia_ff < cnt_a_ff) && (ib_ff < cnt_b_ff), "merge cursor beyond list length")
   `SLIX_ASSERT_IMPLIES(a_push_has_room, rsp_push, rsp_can_push,
      "result pushed into a full output register")
   `SLIX_ASSERT_NEXT(a_flush_clears, (state_ff == ST_FLUSH) && rsp_can_push,
      (cnt_a_ff == '0) && (cnt_b_ff == '0) && !ovf_ff && (state_ff == ST_IDLE),
      "run end did not clear lists")
   `SLIX_ASSERT_NEXT(a_full_sets_ovf,
      req_accept && (req_chan.action == slix_pkg::ACT_LOAD_A) && (cnt_a_ff == CountFull),
      ovf_ff, "dropped load did not flag overflow")

endmodule

// ===== tb/tb_sorted_list_intersection_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for sorted_list_intersection_core
// Loads two lists of signed values, starts runs and checks every result
// transaction against a behavioral prediction of the sort-and-merge
// intersection. Directed cases come first, then random sets with idle bursts
// on both channels, and a closing stretch at full rate.
// ----------------------------------------------------------------------------
module tb_sorted_list_intersection_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [slix_pkg::ValueWidth-1:0] value_type;

   localparam int MAX_ITEMS = 32;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 150;
   localparam slix_pkg::action_type ACT_UNUSED = 2'd3;
   localparam value_type MOST_NEG = 32'sh8000_0000;
   localparam value_type MOST_POS = 32'sh7FFF_FFFF;

   logic clock;
   logic reset;

   slix_req_if req_chan ();
   slix_rsp_if rsp_chan ();

   sorted_list_intersection_core #(
      .MAX_ITEMS(MAX_ITEMS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // Predicted contents of the two lists and the dropped-load flag.
   value_type held_a[$];
   value_type held_b[$];
   logic   load_dropped;
   slix_pkg::rsp_payload_type expected_common[$];

   int error_count = 0;
   int items_sent = 0;
   int src_idle_odds = 0;
   int sink_idle_odds = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void sort_ascending(ref value_type v[$]);
      value_type x;
      int j;
      for (int i = 1; i < v.size(); i++) begin
         x = v[i];
         j = i;
         while (j > 0 && v[j-1] > x) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = x;
      end
   endfunction

   // Updates the predicted lists for one accepted request and, on a run,
   // queues the common values that the merge finds.
   function automatic void apply_to_lists(slix_pkg::action_type act, value_type val);
      slix_pkg::rsp_payload_type run_out[$];
      int ia;
      int ib;
      unique case (act)
         slix_pkg::ACT_LOAD_A: begin
            if (held_a.size() < MAX_ITEMS) held_a.push_back(val);
            else load_dropped = 1'b1;
         end
         slix_pkg::ACT_LOAD_B: begin
            if (held_b.size() < MAX_ITEMS) held_b.push_back(val);
            else load_dropped = 1'b1;
         end
         slix_pkg::ACT_RUN: begin
            sort_ascending(held_a);
            sort_ascending(held_b);
            ia = 0;
            ib = 0;
            while (ia < held_a.size() && ib < held_b.size() &&
                   run_out.size() < slix_pkg::ResultLimit) begin
               if (held_a[ia] < held_b[ib]) begin
                  ia++;
               end else if (held_a[ia] > held_b[ib]) begin
                  ib++;
               end else begin
                  run_out.push_back('{common_value: held_a[ia], is_last: 1'b0,
                                      is_empty: 1'b0, overflow: load_dropped});
                  ia++;
                  ib++;
               end
            end
            if (run_out.size() == 0) begin
               run_out.push_back('{common_value: '0, is_last: 1'b1, is_empty: 1'b1,
                                   overflow: load_dropped});
            end else begin
               run_out[run_out.size()-1].is_last = 1'b1;
            end
            foreach (run_out[k]) expected_common.push_back(run_out[k]);
            held_a.delete();
            held_b.delete();
            load_dropped = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // Called right after a rising edge. valid stays high into the next call
   // unless an idle burst is taken first.
   task automatic send_item(slix_pkg::action_type act, value_type val);
      if (src_idle_odds != 0 && $urandom_range(1, src_idle_odds) == 1) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= act;
      req_chan.value <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      apply_to_lists(act, val);
      if (act != ACT_UNUSED) items_sent++;
   endtask

   task automatic check_result();
      slix_pkg::rsp_payload_type want;
      if (expected_common.size() == 0) begin
         $display("%0t: unexpected result transaction, value %0d last %b empty %b ovf %b",
                  $time, rsp_chan.common_value, rsp_chan.is_last, rsp_chan.is_empty,
                  rsp_chan.overflow);
         error_count++;
      end else begin
         want = expected_common.pop_front();
         if (rsp_chan.common_value !== want.common_value) begin
            $display("%0t: common_value mismatch, expected %0d actual %0d",
                     $time, want.common_value, rsp_chan.common_value);
            error_count++;
         end
         if (rsp_chan.is_last !== want.is_last) begin
            $display("%0t: is_last mismatch, expected %b actual %b",
                     $time, want.is_last, rsp_chan.is_last);
            error_count++;
         end
         if (rsp_chan.is_empty !== want.is_empty) begin
            $display("%0t: is_empty mismatch, expected %b actual %b",
                     $time, want.is_empty, rsp_chan.is_empty);
            error_count++;
         end
         if (rsp_chan.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %b actual %b",
                     $time, want.overflow, rsp_chan.overflow);
            error_count++;
         end
      end
   endtask

   // Result side: check accepted transactions and stall in random bursts.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_result();
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!reset && sink_idle_odds != 0 &&
                      $urandom_range(1, sink_idle_odds) == 1) begin
            stall_left = $urandom_range(0, 5);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // The watchdog restarts whenever either channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding",
                  $time, expected_common.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_odds();
      int r;
      r = $urandom_range(0, 3);
      unique case (r)
         0: return 0;
         1: return 2;
         2: return 5;
         default: return 10;
      endcase
   endfunction

   // Most values sit near a per-set base so that the lists share entries.
   function automatic value_type pick_value(value_type base);
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return base + value_type'($urandom_range(0, 11));
      if (r < 9) return value_type'($urandom);
      unique case ($urandom_range(0, 3))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return '0;
         default: return -1;
      endcase
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(30, 34);
      return $urandom_range(1, 8);
   endfunction

   task automatic load_both(value_type a[], value_type b[]);
      foreach (a[k]) send_item(slix_pkg::ACT_LOAD_A, a[k]);
      foreach (b[k]) send_item(slix_pkg::ACT_LOAD_B, b[k]);
      send_item(slix_pkg::ACT_RUN, value_type'($urandom));
   endtask

   task automatic test_empty_lists();
      send_item(slix_pkg::ACT_RUN, '0);
      send_item(slix_pkg::ACT_LOAD_A, 42);
      send_item(slix_pkg::ACT_RUN, MOST_POS);
      send_item(slix_pkg::ACT_LOAD_B, 42);
      send_item(slix_pkg::ACT_RUN, MOST_NEG);
   endtask

   task automatic test_extreme_values();
      load_both('{MOST_POS, MOST_NEG, 0, -1, 1}, '{-1, MOST_NEG, MOST_POS, 2});
   endtask

   task automatic test_duplicates();
      load_both('{5, 5, 5, -3}, '{5, -3, 5, -3});
   endtask

   task automatic test_disjoint_lists();
      load_both('{1, 3}, '{2, 4});
   endtask

   task automatic test_ignored_action();
      send_item(slix_pkg::ACT_LOAD_A, 7);
      send_item(ACT_UNUSED, 7);
      send_item(ACT_UNUSED, MOST_NEG);
      send_item(slix_pkg::ACT_LOAD_B, 7);
      send_item(slix_pkg::ACT_RUN, '0);
   endtask

   // A fills past capacity in descending order, which is the longest
   // insertion walk, and B holds the same values: the first run uses every result.
   task automatic test_full_lists();
      value_type base;
      base = value_type'($urandom);
      for (int k = MAX_ITEMS; k >= 0; k--) begin
         send_item(slix_pkg::ACT_LOAD_A, base + value_type'(3 * k));
      end
      for (int k = 0; k < MAX_ITEMS; k++) begin
         send_item(slix_pkg::ACT_LOAD_B, base + value_type'(3 * k + 3));
      end
      send_item(slix_pkg::ACT_RUN, '0);
      for (int k = 0; k < 3; k++) send_item(slix_pkg::ACT_LOAD_A, base + value_type'(k));
      for (int k = 0; k <= MAX_ITEMS; k++) begin
         send_item(slix_pkg::ACT_LOAD_B, base + value_type'(MAX_ITEMS - k));
      end
      send_item(slix_pkg::ACT_RUN, '0);
   endtask

   task automatic run_random_set();
      value_type base;
      int left_a;
      int left_b;
      left_a = pick_length();
      left_b = pick_length();
      case ($urandom_range(0, 7))
         0: base = MOST_NEG;
         1: base = MOST_POS - 5;
         2: base = -6;
         default: base = value_type'($urandom);
      endcase
      while (left_a > 0 || left_b > 0) begin
         if ($urandom_range(0, 19) == 0) send_item(ACT_UNUSED, value_type'($urandom));
         if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 0)) begin
            send_item(slix_pkg::ACT_LOAD_A, pick_value(base));
            left_a--;
         end else begin
            send_item(slix_pkg::ACT_LOAD_B, pick_value(base));
            left_b--;
         end
      end
      send_item(slix_pkg::ACT_RUN, value_type'($urandom));
   endtask

   task automatic test_random_sets(int target);
      while (items_sent < target) begin
         src_idle_odds = pick_odds();
         sink_idle_odds = pick_odds();
         run_random_set();
      end
   endtask

   task automatic test_full_rate(int target);
      src_idle_odds = 0;
      sink_idle_odds = 0;
      while (items_sent < target) run_random_set();
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.action <= slix_pkg::ACT_LOAD_A;
      req_chan.value <= '0;
      held_a.delete();
      held_b.delete();
      load_dropped = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      test_empty_lists();
      test_extreme_values();
      test_duplicates();
      test_disjoint_lists();
      test_ignored_action();
      src_idle_odds = 4;
      sink_idle_odds = 4;
      test_full_lists();
      test_random_sets(400);
      test_full_rate(470);

      req_chan.valid <= 1'b0;
      while (expected_common.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/slix_pkg.sv
src/slix_chan_if.sv
src/slix_ram.sv
src/slix_rsp_buf.sv
src/sorted_list_intersection_core.sv
tb/tb_sorted_list_intersection_core.sv
